### hdl/lz77_group_decompressor_macros.svh
// Assertion macros shared by the checker of the LZ77 group decompressor.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef LZ77_GROUP_DECOMPRESSOR_MACROS_SVH
`define LZ77_GROUP_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZGD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lzgd_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the LZ77 group decompressor. No dependencies.
`default_nettype none

package lzgd_pkg;

    localparam int BYTE_W            = 8;
    localparam int OUT_W             = 64;
    localparam int OUT_CNT_W         = 4;
    localparam int STATUS_W          = 2;
    localparam int LEN_W             = 9;
    localparam int SLOT_W            = 4;
    localparam int MIN_LEN           = 3;
    localparam int GROUP_TOKENS      = 8;

    localparam int DEF_OUT_LANES     = 8;
    localparam int DEF_HISTORY_DEPTH = 256;
    localparam int DEF_COUNT_WIDTH   = 24;

    localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIST_ERR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_GROUP_ERR = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic issue_read;
        logic flush;
        logic flush_last;
    } lzgd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic copy_done;
        logic rd_inflight;
        logic room;
        logic asm_full;
        logic out_free;
    } lzgd_sts_t;

endpackage

`default_nettype wire

### hdl/lz77_group_decompressor.sv
// Top level of the LZ77 group decompressor: controller plus datapath.
// Depends on lzgd_pkg, lzgd_ctrl, lzgd_datapath (and lzgd_ram below it).
//
// The block takes one compressed byte per input transaction. A control byte
// opens a group of eight tokens, low bit first: a clear bit means a literal
// byte, a set bit means a length byte (length minus 3) and then a distance
// byte (distance minus 1) that copies from a 256-entry history ring; copies
// may overlap their own output. Every input transaction yields one or more
// output transactions of up to OUT_LANES bytes each (first byte in bits
// 7:0, unused lanes zero); a byte that produces nothing still yields one
// transaction with byte_count 0. last_of_run marks the final transaction of
// each input byte, and status carries the stream status after that byte:
// running, complete, distance error or group error. Once a stream is
// complete or in error, bytes are ignored until first_of_stream is seen.
// Sequence, with the output register free: a control byte, length byte,
// literal or ignored byte is accepted, then its run is handed to the
// output register. A match is accepted, then its bytes are read in turn
// on the single read port of the history RAM; after the read latency the
// closing run is handed off, and each earlier full run costs a hand-off
// and a bubble in the read pipe. A run held back by out_ready delays
// the rest. total_bytes is written through cfg_we/cfg_wdata and may only
// change while the block is idle. The history RAM needs no clearing after
// reset.
`default_nettype none

module lz77_group_decompressor #(
    parameter int OUT_LANES     = lzgd_pkg::DEF_OUT_LANES,
    parameter int HISTORY_DEPTH = lzgd_pkg::DEF_HISTORY_DEPTH,
    parameter int COUNT_WIDTH   = lzgd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // compressed byte channel
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [lzgd_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                           first_of_stream,
    input  wire logic                           last_of_stream,
    // decompressed run channel
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [lzgd_pkg::OUT_W-1:0]     out_bytes,
    output      logic [lzgd_pkg::OUT_CNT_W-1:0] byte_count,
    output      logic [lzgd_pkg::STATUS_W-1:0]  status,
    output      logic                           last_of_run,
    // total_bytes register write
    input  wire logic                           cfg_we,
    input  wire logic [COUNT_WIDTH-1:0]         cfg_wdata
);

    // command and status bundles between controller and datapath
    lzgd_pkg::lzgd_cmd_t cmd;
    lzgd_pkg::lzgd_sts_t sts;

    // Controller: accept a byte in idle, then issue history reads and hand
    // runs to the output register until the closing run is out.
    lzgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: parse the byte, keep stream status, copy through the ring,
    // assemble runs and hold the output transaction until it is taken.
    lzgd_datapath #(
        .OUT_LANES     (OUT_LANES),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_byte         (in_byte),
        .first_of_stream (first_of_stream),
        .last_of_stream  (last_of_stream),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_bytes       (out_bytes),
        .byte_count      (byte_count),
        .status          (status),
        .last_of_run     (last_of_run)
    );

endmodule

`default_nettype wire

### hdl/lzgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lzgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/lzgd_ctrl.sv
// Controller of the LZ77 group decompressor: sequences accept, copy reads
// and run flushes. Depends on lzgd_pkg.
`default_nettype none

module lzgd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire lzgd_pkg::lzgd_sts_t sts,
    output      lzgd_pkg::lzgd_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   final_ready;

    always_comb
    begin
        final_ready    = sts.copy_done && !sts.rd_inflight;
        in_ready       = (state_reg == S_IDLE);
        cmd.accept     = (state_reg == S_IDLE) && in_valid;
        cmd.issue_read = (state_reg == S_RUN) && !sts.copy_done && sts.room;
        cmd.flush      = (state_reg == S_RUN) && sts.out_free
                         && (sts.asm_full || final_ready);
        cmd.flush_last = final_ready;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                // drop back to idle once the closing run is handed off
                if (cmd.flush && final_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/lzgd_datapath.sv
// Datapath of the LZ77 group decompressor: token parser, stream status,
// history ring, copy pointers, run assembly and output register.
// Depends on lzgd_pkg and lzgd_ram.
`default_nettype none

module lzgd_datapath #(
    parameter int OUT_LANES     = lzgd_pkg::DEF_OUT_LANES,
    parameter int HISTORY_DEPTH = lzgd_pkg::DEF_HISTORY_DEPTH,
    parameter int COUNT_WIDTH   = lzgd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [lzgd_pkg::BYTE_W-1:0]       in_byte,
    input  wire logic                              first_of_stream,
    input  wire logic                              last_of_stream,
    input  wire logic                              cfg_we,
    input  wire logic [COUNT_WIDTH-1:0]            cfg_wdata,
    input  wire lzgd_pkg::lzgd_cmd_t               cmd,
    output      lzgd_pkg::lzgd_sts_t               sts,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [lzgd_pkg::OUT_W-1:0]        out_bytes,
    output      logic [lzgd_pkg::OUT_CNT_W-1:0]    byte_count,
    output      logic [lzgd_pkg::STATUS_W-1:0]     status,
    output      logic                              last_of_run
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = COUNT_WIDTH + 2;
    localparam int CNT_W  = $clog2(OUT_LANES + 1);
    localparam int BW     = lzgd_pkg::BYTE_W;
    localparam int LEN_W  = lzgd_pkg::LEN_W;
    localparam int SLOT_W = lzgd_pkg::SLOT_W;
    localparam int ST_W   = lzgd_pkg::STATUS_W;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_TOKEN   = 2'd1,
        PH_DIST    = 2'd2
    } phase_t;

    // stream state
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] bw_reg, bw_next;
    logic [BW-1:0]          ctl_reg, ctl_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    phase_t                 phase_reg, phase_next;
    logic [BW-1:0]          plen_reg, plen_next;
    logic [ST_W-1:0]        stat_reg, stat_next;

    // copy engine and run assembly
    logic [ADDR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [LEN_W-1:0]       remain_reg, remain_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   byp_hit_reg, byp_hit_next;
    logic [BW-1:0]          byp_data_reg, byp_data_next;
    logic [BW-1:0]          asm_reg [OUT_LANES];
    logic [BW-1:0]          asm_next [OUT_LANES];
    logic [CNT_W-1:0]       asm_cnt_reg, asm_cnt_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [lzgd_pkg::OUT_W-1:0]    out_bytes_reg, out_bytes_next;
    logic [lzgd_pkg::OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [ST_W-1:0]               out_stat_reg, out_stat_next;
    logic                          out_last_reg, out_last_next;

    // decode of the byte at the input
    logic [COUNT_WIDTH-1:0] bw0;
    logic [BW-1:0]          ctl0;
    logic [SLOT_W-1:0]      slot0;
    phase_t                 phase0;
    logic [BW-1:0]          plen0;
    logic [ST_W-1:0]        st0, st1, st2;
    logic [SLOT_W-1:0]      slot_inc;
    logic [LEN_W-1:0]       match_len;
    logic [LEN_W-1:0]       emit_len;
    logic [SUM_W-1:0]       dist_ext, total_ext, bw_sum;
    logic                   is_lit, is_copy;
    logic [ADDR_W-1:0]      rd_start;

    // history ring port
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [BW-1:0]          ram_wdata;
    logic [BW-1:0]          ram_rdata;
    logic [BW-1:0]          arr_data;
    logic [CNT_W:0]         fill_sum;
    logic [lzgd_pkg::OUT_W-1:0] packed_run;

    lzgd_ram #(
        .WIDTH (BW),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue_read),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // parse one compressed byte against the (possibly cleared) stream state
    always_comb
    begin
        bw0      = first_of_stream ? '0 : bw_reg;
        ctl0     = first_of_stream ? '0 : ctl_reg;
        slot0    = first_of_stream ? SLOT_W'(lzgd_pkg::GROUP_TOKENS) : slot_reg;
        phase0   = first_of_stream ? PH_CONTROL : phase_reg;
        plen0    = first_of_stream ? '0 : plen_reg;
        st0      = first_of_stream ? lzgd_pkg::ST_RUNNING : stat_reg;
        total_ext = SUM_W'(total_reg);
        match_len = LEN_W'(plen0) + LEN_W'(lzgd_pkg::MIN_LEN);
        dist_ext  = SUM_W'(in_byte) + SUM_W'(1);
        slot_inc  = slot0 + SLOT_W'(1);
        rd_start  = ADDR_W'(bw0) - ADDR_W'(in_byte) - ADDR_W'(1);

        st1 = st0;
        if (st0 == lzgd_pkg::ST_RUNNING)
        begin
            if (SUM_W'(bw0) == total_ext)
            begin
                st1 = lzgd_pkg::ST_DONE;
            end
            else if (SUM_W'(bw0) > total_ext)
            begin
                st1 = lzgd_pkg::ST_GROUP_ERR;
            end
        end

        ctl_next   = ctl0;
        slot_next  = slot0;
        phase_next = phase0;
        plen_next  = plen0;
        st2        = st1;
        is_lit     = 1'b0;
        is_copy    = 1'b0;
        emit_len   = '0;

        if (st1 == lzgd_pkg::ST_RUNNING)
        begin
            case (phase0)
                PH_CONTROL:
                begin
                    ctl_next   = in_byte;
                    slot_next  = '0;
                    phase_next = PH_TOKEN;
                end
                PH_TOKEN:
                begin
                    if (ctl0[slot0[2:0]])
                    begin
                        plen_next  = in_byte;
                        phase_next = PH_DIST;
                    end
                    else
                    begin
                        is_lit   = 1'b1;
                        emit_len = LEN_W'(1);
                    end
                end
                PH_DIST:
                begin
                    if (dist_ext > SUM_W'(bw0))
                    begin
                        st2 = lzgd_pkg::ST_DIST_ERR;
                    end
                    else if (SUM_W'(bw0) + SUM_W'(match_len) > total_ext)
                    begin
                        st2 = lzgd_pkg::ST_GROUP_ERR;
                    end
                    else
                    begin
                        is_copy  = 1'b1;
                        emit_len = match_len;
                    end
                end
                default:
                begin
                    phase_next = PH_CONTROL;
                end
            endcase

            // advance to the next token slot after a literal or a match
            if (is_lit || is_copy)
            begin
                if (slot_inc >= SLOT_W'(lzgd_pkg::GROUP_TOKENS))
                begin
                    slot_next  = SLOT_W'(lzgd_pkg::GROUP_TOKENS);
                    phase_next = PH_CONTROL;
                end
                else
                begin
                    slot_next  = slot_inc;
                    phase_next = PH_TOKEN;
                end
            end
        end

        bw_sum = SUM_W'(bw0) + SUM_W'(emit_len);
        stat_next = st2;
        if (st1 == lzgd_pkg::ST_RUNNING && st2 == lzgd_pkg::ST_RUNNING)
        begin
            if (bw_sum == total_ext)
            begin
                stat_next = lzgd_pkg::ST_DONE;
            end
            else if (bw_sum > total_ext)
            begin
                stat_next = lzgd_pkg::ST_GROUP_ERR;
            end
            else if (last_of_stream)
            begin
                stat_next = lzgd_pkg::ST_GROUP_ERR;
            end
        end
        bw_next = bw_sum[COUNT_WIDTH-1:0];
    end

    // history ring writes: literals at accept, copied bytes as they return
    always_comb
    begin
        arr_data  = byp_hit_reg ? byp_data_reg : ram_rdata;
        ram_we    = (cmd.accept && is_lit) || rd_valid_reg;
        ram_waddr = rd_valid_reg ? wr_ptr_reg : ADDR_W'(bw0);
        ram_wdata = rd_valid_reg ? arr_data : in_byte;
    end

    // pack the assembled run, unused lanes zero
    always_comb
    begin
        packed_run = '0;
        for (int k = 0; k < OUT_LANES; k++)
        begin
            if (CNT_W'(k) < asm_cnt_reg)
            begin
                packed_run[k*BW +: BW] = asm_reg[k];
            end
        end
    end

    always_comb
    begin
        total_next    = cfg_we ? cfg_wdata : total_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        remain_next   = remain_reg;
        rd_valid_next = 1'b0;
        byp_hit_next  = 1'b0;
        byp_data_next = ram_wdata;
        asm_cnt_next  = asm_cnt_reg;
        for (int k = 0; k < OUT_LANES; k++)
        begin
            asm_next[k] = asm_reg[k];
        end

        if (cmd.accept)
        begin
            rd_ptr_next  = rd_start;
            wr_ptr_next  = ADDR_W'(bw0);
            remain_next  = is_copy ? match_len : '0;
            asm_cnt_next = is_lit ? CNT_W'(1) : '0;
            asm_next[0]  = in_byte;
        end

        if (cmd.issue_read)
        begin
            rd_ptr_next   = rd_ptr_reg + ADDR_W'(1);
            remain_next   = remain_reg - LEN_W'(1);
            rd_valid_next = 1'b1;
            // forward a byte written in the same cycle it is read
            byp_hit_next  = ram_we && (ram_waddr == rd_ptr_reg);
        end

        if (rd_valid_reg)
        begin
            wr_ptr_next  = wr_ptr_reg + ADDR_W'(1);
            asm_cnt_next = asm_cnt_reg + CNT_W'(1);
            for (int k = 0; k < OUT_LANES; k++)
            begin
                if (CNT_W'(k) == asm_cnt_reg)
                begin
                    asm_next[k] = arr_data;
                end
            end
        end

        if (cmd.flush)
        begin
            asm_cnt_next = '0;
        end

        out_bytes_next = out_bytes_reg;
        out_cnt_next   = out_cnt_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (cmd.flush)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = packed_run;
            out_cnt_next   = lzgd_pkg::OUT_CNT_W'(asm_cnt_reg);
            out_stat_next  = stat_reg;
            out_last_next  = cmd.flush_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            bw_reg        <= '0;
            ctl_reg       <= '0;
            slot_reg      <= SLOT_W'(lzgd_pkg::GROUP_TOKENS);
            phase_reg     <= PH_CONTROL;
            plen_reg      <= '0;
            stat_reg      <= lzgd_pkg::ST_RUNNING;
            remain_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            asm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            if (cmd.accept)
            begin
                bw_reg    <= bw_next;
                ctl_reg   <= ctl_next;
                slot_reg  <= slot_next;
                phase_reg <= phase_next;
                plen_reg  <= plen_next;
                stat_reg  <= stat_next;
            end
            remain_reg    <= remain_next;
            rd_valid_reg  <= rd_valid_next;
            asm_cnt_reg   <= asm_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        wr_ptr_reg    <= wr_ptr_next;
        byp_hit_reg   <= byp_hit_next;
        byp_data_reg  <= byp_data_next;
        out_bytes_reg <= out_bytes_next;
        out_cnt_reg   <= out_cnt_next;
        out_stat_reg  <= out_stat_next;
        out_last_reg  <= out_last_next;
        for (int k = 0; k < OUT_LANES; k++)
        begin
            asm_reg[k] <= asm_next[k];
        end
    end

    always_comb
    begin
        fill_sum        = (CNT_W+1)'(asm_cnt_reg) + (CNT_W+1)'(rd_valid_reg);
        sts.copy_done   = (remain_reg == '0);
        sts.rd_inflight = rd_valid_reg;
        sts.room        = fill_sum < (CNT_W+1)'(OUT_LANES);
        sts.asm_full    = (asm_cnt_reg == CNT_W'(OUT_LANES));
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_bytes   = out_bytes_reg;
    assign byte_count  = out_cnt_reg;
    assign status      = out_stat_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

### hdl/lzgd_checker.sv
// Port-level assertion checker for the LZ77 group decompressor, bound to
// the top level. Depends on lzgd_pkg and lz77_group_decompressor_macros.svh.
`default_nettype none

`include "lz77_group_decompressor_macros.svh"

module lzgd_checker #(
    parameter int OUT_LANES = lzgd_pkg::DEF_OUT_LANES
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [lzgd_pkg::OUT_W-1:0]     out_bytes,
    input wire logic [lzgd_pkg::OUT_CNT_W-1:0] byte_count,
    input wire logic [lzgd_pkg::STATUS_W-1:0]  status,
    input wire logic                           last_of_run
);

    // a stalled output transaction holds its payload
    `LZGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bytes) && $stable(byte_count), "output payload changed while stalled")

    // only one compressed byte is in work at a time
    `LZGD_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "input accepted while a byte is still in work")

    // every run but the closing one is full
    `LZGD_ASSERT_NOW(a_full_runs, out_valid && !last_of_run, byte_count == lzgd_pkg::OUT_CNT_W'(OUT_LANES), "intermediate run is not full")

    // a distance error never comes with output bytes
    `LZGD_ASSERT_NOW(a_dist_err_empty, out_valid && status == lzgd_pkg::ST_DIST_ERR, byte_count == '0, "bytes delivered with a distance error")

endmodule

bind lz77_group_decompressor lzgd_checker #(
    .OUT_LANES (OUT_LANES)
) u_lzgd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .status      (status),
    .last_of_run (last_of_run)
);

`default_nettype wire
